### rtl/shap_pkg.sv
package shap_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] hash_vec_t;
    typedef logic [15:0][31:0] block_vec_t;

    // Status of the compression core as seen by the register front end.
    typedef struct packed {
        logic busy;
        logic done;
    } shap_status_t;

    // Word indexes of the register map (byte address divided by four).
    localparam logic [13:0] IDX_HASH7    = 14'h03;
    localparam logic [13:0] IDX_BLOCK_LO = 14'h04;
    localparam logic [13:0] IDX_BLOCK_HI = 14'h14;
    localparam logic [13:0] IDX_HASH_LO  = 14'h18;
    localparam logic [13:0] IDX_HASH_HI  = 14'h20;

    // Command byte fields on port 0.
    localparam int unsigned CMD_CLEAR_BIT = 4;
    localparam logic [7:0]  CMD_INIT_MASK = 8'h0E;
    localparam logic [7:0]  CMD_INIT_CODE = 8'h0A;
    localparam logic [7:0]  CMD_RUN_MASK  = 8'h0A;

    // Standard initial hash values.
    function automatic word_t init_hash(input logic [2:0] i);
        word_t v;
        case (i)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    // Round constants.
    function automatic word_t round_k(input logic [5:0] r);
        word_t v;
        case (r)
            6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7; default: v = 32'hc67178f2;
        endcase
        return v;
    endfunction

    // Byte lane of a word, lane 0 being bits 7:0.
    function automatic logic [7:0] lane_get(input word_t w, input logic [1:0] lane);
        logic [7:0] b;
        case (lane)
            2'd0:    b = w[7:0];
            2'd1:    b = w[15:8];
            2'd2:    b = w[23:16];
            default: b = w[31:24];
        endcase
        return b;
    endfunction

endpackage

### rtl/shap_core.sv
module shap_core
    import shap_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  hash_vec_t    hash_in,
    input  block_vec_t   block_in,
    output shap_status_t status,
    output hash_vec_t    hash_sum
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_FINAL = 3'b100
    } core_state_t;

    core_state_t state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    hash_vec_t   v_reg;
    block_vec_t  w_reg;

    word_t t1, t2, sig0, sig1, big0, big1, ch, maj, w_new;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One round of the compression and one step of the message schedule.
    always_comb
    begin
        big0  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        big1  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + big1 + ch + round_k(round_reg) + w_reg[0];
        t2    = big0 + maj;
        sig0  = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        sig1  = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + sig0 + w_reg[9] + sig1;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                round_next = 6'd0;
                if (start)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    // Working variables and schedule window.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            v_reg <= hash_in;
            w_reg <= block_in;
        end
        else if (state_reg == ST_ROUND)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end
    end

    // Final addition into the hash state.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            hash_sum[i] = hash_in[i] + v_reg[i];
        end
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = (state_reg == ST_FINAL);

endmodule

### rtl/sha256_register_peripheral.sv
// Channel | Signals                                   | Direction
// in      | in_valid, in_ready, action, port_address, | into block
//         | write_data, debug_access, ports_unlocked, |
//         | flash_open                                |
// out     | out_valid, out_ready, read_data           | out of block
//
// The result of a read or an ordinary write is registered in the output
// register and sits there while the next transaction is taken.
// A command that runs a compression holds in_ready low while start_reg starts
// the round unit, through 64 rounds on the shared round unit and one final addition.
// Reset clears the hash state, the block and the last index.
// A stalled output holds in_ready low until its transaction is taken.
module sha256_register_peripheral
    import shap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [15:0] port_address,
    input  logic [7:0]  write_data,
    input  logic        debug_access,
    input  logic        ports_unlocked,
    input  logic        flash_open,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data
);

    hash_vec_t    hash_reg;
    block_vec_t   block_reg;
    logic [13:0]  last_index_reg;
    logic         start_reg;
    logic         out_valid_reg;
    logic [7:0]   read_data_reg;

    shap_status_t core_status;
    hash_vec_t    hash_sum;

    logic         accept;
    logic         access_ok;
    logic [13:0]  eff_idx;
    logic [1:0]   lane;
    logic [3:0]   blk_sel;
    logic [3:0]   blk_wsel;
    logic [7:0]   rd_byte;
    logic         is_cmd;
    logic         cmd_clear;
    logic         cmd_init;
    logic         cmd_run;
    logic         blk_write;

    shap_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .hash_in  (hash_reg),
        .block_in (block_reg),
        .status   (core_status),
        .hash_sum (hash_sum)
    );

    // Handshake.
    assign in_ready  = !start_reg && !core_status.busy && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    // Access decode.
    always_comb
    begin
        access_ok = debug_access || ports_unlocked;
        lane      = port_address[1:0];
        eff_idx   = access_ok ? port_address[15:2] : last_index_reg;
        blk_sel   = eff_idx[3:0] - 4'd4;
        blk_wsel  = port_address[5:2] - 4'd4;
        is_cmd    = action && access_ok && (port_address == 16'd0) && flash_open;
        cmd_clear = is_cmd && write_data[CMD_CLEAR_BIT];
        cmd_init  = is_cmd && !write_data[CMD_CLEAR_BIT]
                    && ((write_data & CMD_INIT_MASK) == CMD_INIT_CODE);
        cmd_run   = is_cmd && !write_data[CMD_CLEAR_BIT]
                    && ((write_data & CMD_RUN_MASK) == CMD_RUN_MASK);
        blk_write = action && access_ok && !is_cmd
                    && (port_address[15:2] >= IDX_BLOCK_LO)
                    && (port_address[15:2] < IDX_BLOCK_HI);
    end

    // Read map.
    always_comb
    begin
        rd_byte = 8'd0;
        if (!action)
        begin
            if (eff_idx == IDX_HASH7)
            begin
                rd_byte = lane_get(hash_reg[7], lane);
            end
            else if (eff_idx >= IDX_BLOCK_LO && eff_idx < IDX_BLOCK_HI)
            begin
                rd_byte = lane_get(block_reg[blk_sel], lane);
            end
            else if (eff_idx >= IDX_HASH_LO && eff_idx < IDX_HASH_HI)
            begin
                rd_byte = lane_get(hash_reg[eff_idx[2:0]], lane);
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg       <= '0;
            block_reg      <= '0;
            last_index_reg <= '0;
            start_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= accept && cmd_run;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (core_status.done)
            begin
                hash_reg <= hash_sum;
            end
            else if (accept && cmd_clear)
            begin
                hash_reg <= '0;
            end
            else if (accept && cmd_init)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= init_hash(3'(i));
                end
            end
            if (accept && blk_write)
            begin
                block_reg[blk_wsel][{lane, 3'b000} +: 8] <= write_data;
            end
            if (accept && !debug_access && ports_unlocked)
            begin
                last_index_reg <= port_address[15:2];
            end
        end
    end

    // Output data register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= rd_byte;
        end
    end

    // Checks.
    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd_run |=> start_reg)
        else $error("compression command did not start the core");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> !core_status.busy)
        else $error("core started while busy");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        core_status.busy |-> !in_ready)
        else $error("transaction taken during compression");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        core_status.done |=> !core_status.busy)
        else $error("core stayed busy after its final addition");

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;

    // Access kinds on the action field.
    localparam bit ACT_READ  = 1'b0;
    localparam bit ACT_WRITE = 1'b1;

    // Word indexes of the register map.
    localparam int unsigned MAP_HASH_TAIL   = 'h03;
    localparam int unsigned MAP_BLOCK_FIRST = 'h04;
    localparam int unsigned MAP_BLOCK_LAST  = 'h13;
    localparam int unsigned MAP_HASH_FIRST  = 'h18;
    localparam int unsigned MAP_HASH_LAST   = 'h1F;

    // Byte addresses used by the stimulus.
    localparam logic [15:0] ADDR_COMMAND     = 16'h0000;
    localparam logic [15:0] ADDR_HASH_TAIL   = 16'h000C;
    localparam logic [15:0] ADDR_BLOCK_BASE  = 16'h0010;
    localparam logic [15:0] ADDR_UNMAPPED    = 16'h0050;
    localparam logic [15:0] ADDR_HASH_BASE   = 16'h0060;

    // Command byte decoding on port 0.
    localparam int unsigned CMD_CLEAR_BIT = 4;
    localparam logic [7:0]  CMD_INIT_MASK = 8'h0E;
    localparam logic [7:0]  CMD_INIT_CODE = 8'h0A;
    localparam logic [7:0]  CMD_RUN_MASK  = 8'h0A;
    localparam logic [7:0]  CMD_INIT_RUN  = 8'h0A;
    localparam logic [7:0]  CMD_INIT_RUN1 = 8'h0B;
    localparam logic [7:0]  CMD_RUN_ONLY  = 8'h0E;
    localparam logic [7:0]  CMD_RUN_ONLY1 = 8'h0F;
    localparam logic [7:0]  CMD_NOTHING   = 8'h08;
    localparam logic [7:0]  CMD_CLEAR     = 8'h10;
    localparam logic [7:0]  CMD_CLEAR_RUN = 8'h1A;

    localparam int RANDOM_ITEMS = 500;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 80;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Scoreboard: mirrors the register file and predicts each returned byte.
    class digest_scoreboard;
        logic [31:0] hash_st [8];
        logic [31:0] blk [16];
        logic [13:0] last_idx;
        logic [7:0]  expected_bytes [$];
        int errors;
        int checked;
        int compressions;
        int clears;
        int locked_out;

        function new();
            for (int i = 0; i < 8; i++)
                hash_st[i] = '0;
            for (int i = 0; i < 16; i++)
                blk[i] = '0;
            last_idx = '0;
            errors = 0;
            checked = 0;
            compressions = 0;
            clears = 0;
            locked_out = 0;
        endfunction

        function logic [31:0] rotr(input logic [31:0] x, input int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // One 64-round compression of the block into the hash state.
        function void compress();
            logic [31:0] sched [64];
            logic [31:0] v [8];
            logic [31:0] s0, s1, t1, t2, ch, maj;
            for (int r = 0; r < 16; r++)
                sched[r] = blk[r];
            for (int r = 16; r < 64; r++)
            begin
                s0 = rotr(sched[r-15], 7) ^ rotr(sched[r-15], 18) ^ (sched[r-15] >> 3);
                s1 = rotr(sched[r-2], 17) ^ rotr(sched[r-2], 19) ^ (sched[r-2] >> 10);
                sched[r] = sched[r-16] + s0 + sched[r-7] + s1;
            end
            for (int r = 0; r < 8; r++)
                v[r] = hash_st[r];
            for (int r = 0; r < 64; r++)
            begin
                s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
                maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
                s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
                ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
                t1  = v[7] + s1 + ch + SHA_K[r] + sched[r];
                t2  = s0 + maj;
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int r = 0; r < 8; r++)
                hash_st[r] = hash_st[r] + v[r];
            compressions++;
        endfunction

        // Note an accepted transaction and queue the byte it should return.
        function void predict_access(input bit act, input logic [15:0] addr,
                                     input logic [7:0] data, input bit dbg,
                                     input bit unl, input bit fl);
            logic [13:0] idx;
            logic [1:0]  lane;
            logic [7:0]  res;
            idx  = addr[15:2];
            lane = addr[1:0];
            res  = '0;
            if (act == ACT_WRITE)
            begin
                if (!dbg && !unl)
                begin
                    // Normal writes are dropped while the ports are locked.
                    locked_out++;
                end
                else
                begin
                    if (!dbg)
                        last_idx = idx;
                    if (addr == ADDR_COMMAND && fl)
                    begin
                        if (data[CMD_CLEAR_BIT])
                        begin
                            for (int i = 0; i < 8; i++)
                                hash_st[i] = '0;
                            clears++;
                        end
                        else
                        begin
                            if ((data & CMD_INIT_MASK) == CMD_INIT_CODE)
                                for (int i = 0; i < 8; i++)
                                    hash_st[i] = SHA_IV[i];
                            if ((data & CMD_RUN_MASK) == CMD_RUN_MASK)
                                compress();
                        end
                    end
                    else if (idx >= MAP_BLOCK_FIRST && idx <= MAP_BLOCK_LAST)
                    begin
                        blk[4'(idx - MAP_BLOCK_FIRST)][lane*8 +: 8] = data;
                    end
                end
            end
            else
            begin
                // A locked normal read reuses the last index, keeping its own lane.
                if (!dbg)
                begin
                    if (unl)
                        last_idx = idx;
                    else
                    begin
                        idx = last_idx;
                        locked_out++;
                    end
                end
                if (idx == MAP_HASH_TAIL)
                    res = hash_st[7][lane*8 +: 8];
                else if (idx >= MAP_BLOCK_FIRST && idx <= MAP_BLOCK_LAST)
                    res = blk[4'(idx - MAP_BLOCK_FIRST)][lane*8 +: 8];
                else if (idx >= MAP_HASH_FIRST && idx <= MAP_HASH_LAST)
                    res = hash_st[3'(idx - MAP_HASH_FIRST)][lane*8 +: 8];
            end
            expected_bytes.push_back(res);
        endfunction

        // Compare a returned byte with the oldest prediction.
        function void check_byte(input logic [7:0] got);
            logic [7:0] want;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: read_data %02h returned with nothing expected", $time, got);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            checked++;
            if (got !== want)
            begin
                $display("%0t: read_data mismatch: expected %02h, actual %02h",
                         $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [15:0] port_address;
    logic [7:0]  write_data;
    logic        debug_access;
    logic        ports_unlocked;
    logic        flash_open;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_data;

    digest_scoreboard sb;
    int send_idle_pct = 13;
    int recv_idle_pct = 88;
    int sent_count = 0;
    int stall_cycles = 0;

    sha256_register_peripheral u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .port_address   (port_address),
        .write_data     (write_data),
        .debug_access   (debug_access),
        .ports_unlocked (ports_unlocked),
        .flash_open     (flash_open),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Send one transaction, with random idle cycles ahead of it.
    task automatic send_access(input bit act, input logic [15:0] addr,
                               input logic [7:0] data, input bit dbg,
                               input bit unl, input bit fl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        action         <= act;
        port_address   <= addr;
        write_data     <= data;
        debug_access   <= dbg;
        ports_unlocked <= unl;
        flash_open     <= fl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.predict_access(act, addr, data, dbg, unl, fl);
        sent_count++;
    endtask

    // Hold the sender back until every predicted byte has been returned.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Write some block bytes, run a compression, then read the digest back.
    task automatic run_digest();
        int n_bytes;
        logic [7:0] cmd;
        bit dbg;
        n_bytes = ($urandom_range(7) == 0) ? 64 : $urandom_range(16, 1);
        for (int i = 0; i < n_bytes; i++)
        begin
            dbg = ($urandom_range(4) == 0);
            send_access(ACT_WRITE,
                        16'(ADDR_BLOCK_BASE + ((n_bytes == 64) ? i : $urandom_range(63))),
                        8'($urandom), dbg, dbg ? 1'($urandom) : 1'b1, 1'($urandom));
        end
        case ($urandom_range(3))
            0:       cmd = CMD_INIT_RUN;
            1:       cmd = CMD_INIT_RUN1;
            2:       cmd = CMD_RUN_ONLY;
            default: cmd = CMD_RUN_ONLY1;
        endcase
        // The top three bits of a command are don't-care.
        cmd[7:5] = 3'($urandom);
        dbg = ($urandom_range(3) == 0);
        send_access(ACT_WRITE, ADDR_COMMAND, cmd, dbg, dbg ? 1'($urandom) : 1'b1, 1'b1);
        for (int i = 0; i < 32; i++)
        begin
            if ($urandom_range(9) == 0)
                send_access(ACT_READ, 16'($urandom), 8'($urandom), 1'b0, 1'b0, 1'($urandom));
            else if ($urandom_range(9) == 0)
                send_access(ACT_READ, 16'(ADDR_HASH_TAIL + $urandom_range(3)), 8'($urandom),
                            1'($urandom), 1'b1, 1'($urandom));
            else
                send_access(ACT_READ, 16'(ADDR_HASH_BASE + i), 8'($urandom),
                            1'($urandom_range(3) == 0), 1'b1, 1'($urandom));
        end
    endtask

    // A burst of unconstrained transactions, commands among them.
    task automatic noise_burst();
        logic [15:0] addr;
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(3))
                0:       addr = ADDR_COMMAND;
                1:       addr = 16'($urandom_range(127));
                default: addr = 16'($urandom);
            endcase
            send_access(1'($urandom), addr, 8'($urandom), 1'($urandom),
                        1'($urandom), 1'($urandom));
        end
    endtask

    // Receiver: checks returned bytes and stalls at random.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_byte(read_data);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("sha256_register_peripheral regression: fail");
        $finish;
    end

    // Main sequence: reset, directed cases, then random traffic in three phases.
    initial
    begin
        int directed_count;
        sb             = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = ACT_READ;
        port_address   = '0;
        write_data     = '0;
        debug_access   = 1'b0;
        ports_unlocked = 1'b0;
        flash_open     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: map edges, lock handling, debug bypass and every command kind.
        send_access(ACT_READ,  ADDR_HASH_BASE, 8'h00, 1'b0, 1'b1, 1'b0);
        send_access(ACT_WRITE, ADDR_BLOCK_BASE, 8'hFF, 1'b0, 1'b1, 1'b0);
        send_access(ACT_WRITE, 16'h004F, 8'h80, 1'b1, 1'b0, 1'b0);
        send_access(ACT_WRITE, 16'h0020, 8'h55, 1'b0, 1'b0, 1'b1);
        send_access(ACT_READ,  ADDR_BLOCK_BASE, 8'h00, 1'b0, 1'b1, 1'b0);
        send_access(ACT_READ,  16'h004F, 8'h00, 1'b1, 1'b0, 1'b0);
        send_access(ACT_READ,  16'h0020, 8'h00, 1'b0, 1'b1, 1'b0);
        send_access(ACT_READ,  16'hFFFF, 8'hFF, 1'b0, 1'b0, 1'b1);
        send_access(ACT_WRITE, ADDR_COMMAND, CMD_INIT_RUN, 1'b0, 1'b1, 1'b0);
        send_access(ACT_WRITE, ADDR_COMMAND, CMD_INIT_RUN, 1'b0, 1'b1, 1'b1);
        send_access(ACT_READ,  ADDR_HASH_BASE, 8'h00, 1'b0, 1'b1, 1'b0);
        send_access(ACT_READ,  16'h0063, 8'h00, 1'b0, 1'b1, 1'b0);
        send_access(ACT_READ,  16'h007F, 8'h00, 1'b0, 1'b1, 1'b0);
        send_access(ACT_READ,  ADDR_HASH_TAIL, 8'h00, 1'b0, 1'b1, 1'b0);
        send_access(ACT_WRITE, ADDR_COMMAND, CMD_RUN_ONLY, 1'b0, 1'b1, 1'b1);
        send_access(ACT_READ,  16'h000F, 8'h00, 1'b0, 1'b0, 1'b0);
        send_access(ACT_WRITE, ADDR_COMMAND, CMD_NOTHING, 1'b0, 1'b1, 1'b1);
        send_access(ACT_READ,  16'h007C, 8'h00, 1'b1, 1'b0, 1'b0);
        send_access(ACT_WRITE, ADDR_COMMAND, CMD_CLEAR_RUN, 1'b0, 1'b1, 1'b1);
        send_access(ACT_READ,  16'h0061, 8'h00, 1'b0, 1'b1, 1'b0);
        send_access(ACT_WRITE, ADDR_COMMAND, CMD_INIT_RUN1, 1'b1, 1'b0, 1'b1);
        send_access(ACT_WRITE, ADDR_COMMAND, CMD_CLEAR, 1'b0, 1'b0, 1'b1);
        send_access(ACT_READ,  ADDR_UNMAPPED, 8'h00, 1'b0, 1'b1, 1'b1);
        send_access(ACT_READ,  16'h000B, 8'h00, 1'b1, 1'b1, 1'b0);
        send_access(ACT_READ,  16'h0062, 8'h00, 1'b1, 1'b0, 1'b0);
        directed_count = sent_count;
        wait_results_drained();

        // Random traffic: mostly complete digest sequences, some noise.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 13;
                    recv_idle_pct = 88;
                end
                1:
                begin
                    send_idle_pct = 88;
                    recv_idle_pct = 13;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (sent_count < directed_count + (phase + 1) * RANDOM_ITEMS / 3)
            begin
                if ($urandom_range(3) == 0)
                    noise_burst();
                else
                    run_digest();
                if ($urandom_range(5) == 0)
                    wait_results_drained();
            end
            wait_results_drained();
        end

        // Let any late output show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d transactions and checked %0d returned bytes.", sent_count, sb.checked);
        $display("Covered %0d compressions, %0d hash clears and %0d locked-out accesses.",
                 sb.compressions, sb.clears, sb.locked_out);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("sha256_register_peripheral regression: pass");
        else
            $display("sha256_register_peripheral regression: fail");
        $finish;
    end

endmodule

### files.f
rtl/shap_pkg.sv
rtl/shap_core.sv
rtl/sha256_register_peripheral.sv
test/tb.sv
